[rtl/rv32_pkg.sv]
// Shared types and constants for the RV32I executor.
package rv32_pkg;

  localparam int DATA_WORDS = 4096;
  localparam int DADDR_W = $clog2(DATA_WORDS);
  localparam int BADDR_W = DADDR_W + 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [6:0] OP_REG = 7'h33;
  localparam logic [6:0] OP_IMM = 7'h13;
  localparam logic [6:0] OP_LOAD = 7'h03;
  localparam logic [6:0] OP_STORE = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JAL = 7'h6f;
  localparam logic [6:0] OP_JALR = 7'h67;
  localparam logic [6:0] OP_LUI = 7'h37;
  localparam logic [6:0] OP_AUIPC = 7'h17;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_STORE = 2'd2;

  localparam logic [0:0] REG_START_PC = 1'b0;
  localparam logic [0:0] REG_START_STACK = 1'b1;

  typedef enum logic [3:0] {
    CLS_NOP = 4'd0, CLS_ALU = 4'd1, CLS_LOAD = 4'd2, CLS_STORE = 4'd3,
    CLS_BRANCH = 4'd4, CLS_JAL = 4'd5, CLS_JALR = 4'd6, CLS_LUI = 4'd7,
    CLS_AUIPC = 4'd8, CLS_HALT = 4'd9
  } cls_t;

  // A classified item handed from the front to the back.
  typedef struct packed {
    cls_t        cls;
    logic [31:0] word;
    logic        alt;
    logic        use_imm;
    logic [31:0] imm;
  } dec_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        wrote_reg;
    logic [4:0]  dest_reg;
    logic [31:0] dest_value;
    logic [1:0]  mem_kind;
    logic [31:0] mem_address;
    logic        halted;
  } res_t;

endpackage

[rtl/rv32_ram.sv]
// Generic single-port RAM with registered read.
module rv32_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/rv32_front.sv]
// Front end: accepts instruction words, classifies them and queues them.
module rv32_front import rv32_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [31:0] instr_word,
  output logic        q_valid,
  input  logic        q_pop,
  output dec_t        q_head
);
  dec_t q [QUEUE_DEPTH];
  logic [$clog2(QUEUE_DEPTH)-1:0] rd_ptr, wr_ptr;
  logic [$clog2(QUEUE_DEPTH):0] count;
  dec_t d;
  logic [6:0] op, f7;
  logic [2:0] f3;
  logic push;

  assign op = instr_word[6:0];
  assign f3 = instr_word[14:12];
  assign f7 = instr_word[31:25];

  always_comb begin
    d.word = instr_word;
    d.alt = 1'b0;
    d.use_imm = 1'b0;
    d.imm = {{20{instr_word[31]}}, instr_word[31:20]};
    d.cls = CLS_NOP;
    if (instr_word == 32'd0) begin
      d.cls = CLS_HALT;
    end else begin
      unique case (op)
        OP_REG: begin
          if (f7 == 7'h00 || (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5))) begin
            d.cls = CLS_ALU;
            d.alt = f7[5];
          end
        end
        OP_IMM: begin
          d.use_imm = 1'b1;
          if (!(f3 == 3'd1 && f7 != 7'h00) &&
              !(f3 == 3'd5 && f7 != 7'h00 && f7 != 7'h20)) begin
            d.cls = CLS_ALU;
            d.alt = (f3 == 3'd5) && f7[5];
          end
        end
        OP_LOAD: begin
          if (f3 != 3'd3 && f3 < 3'd6) d.cls = CLS_LOAD;
        end
        OP_STORE: begin
          d.imm = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
          if (f3 < 3'd3) d.cls = CLS_STORE;
        end
        OP_BRANCH: begin
          d.imm = {{20{instr_word[31]}}, instr_word[7], instr_word[30:25],
                   instr_word[11:8], 1'b0};
          d.cls = CLS_BRANCH;
        end
        OP_JAL: begin
          d.imm = {{12{instr_word[31]}}, instr_word[19:12], instr_word[20],
                   instr_word[30:21], 1'b0};
          d.cls = CLS_JAL;
        end
        OP_JALR: begin
          if (f3 == 3'd0) d.cls = CLS_JALR;
        end
        OP_LUI: begin
          d.imm = {instr_word[31:12], 12'd0};
          d.cls = CLS_LUI;
        end
        OP_AUIPC: begin
          d.imm = {instr_word[31:12], 12'd0};
          d.cls = CLS_AUIPC;
        end
        default: d.cls = CLS_NOP;
      endcase
    end
  end

  assign ready = (count < ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH));
  assign push = valid && ready;
  assign q_valid = (count != '0);
  assign q_head = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= d;
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (push ? 1'b1 : 1'b0) - (q_pop ? 1'b1 : 1'b0);
    end
  end
endmodule

[rtl/rv32_back.sv]
// Back end: reads operands, executes, accesses data memory, writes back.
module rv32_back import rv32_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_pop,
  input  dec_t        q_head,
  input  logic [31:0] start_pc,
  input  logic [31:0] start_stack,
  output logic        busy,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res
);
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001, S_IDLE = 6'b000010, S_EXEC = 6'b000100,
    S_MEM = 6'b001000, S_WB = 6'b010000, S_HOLD = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [31:0] regs [32];
  logic [31:0] pc;
  logic started, halt_flag;
  dec_t cur;
  logic [31:0] a, b, addr, ld_val, val;
  logic [4:0] rd;
  logic [2:0] f3;
  logic [1:0] bidx;
  logic [2:0] nbytes;
  logic [DADDR_W-1:0] clr_cnt;
  logic [DADDR_W-1:0] ram_addr, word_addr;
  logic ram_we;
  logic [31:0] ram_wdata, ram_rdata;
  logic [31:0] alu_out, opb, npc;
  logic take, wr;
  logic wb_go;

  assign f3 = cur.word[14:12];
  assign rd = cur.word[11:7];

  rv32_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_comb begin
    opb = cur.use_imm ? cur.imm : b;
    case (f3)
      3'd0: alu_out = cur.alt ? a - opb : a + opb;
      3'd1: alu_out = a << opb[4:0];
      3'd2: alu_out = {31'd0, $signed(a) < $signed(opb)};
      3'd3: alu_out = {31'd0, a < opb};
      3'd4: alu_out = a ^ opb;
      3'd5: alu_out = cur.alt ? 32'($signed(a) >>> opb[4:0]) : a >> opb[4:0];
      3'd6: alu_out = a | opb;
      default: alu_out = a & opb;
    endcase
    case (f3)
      3'd0: take = (a == b);
      3'd1: take = (a != b);
      3'd4: take = $signed(a) < $signed(b);
      3'd5: take = $signed(a) >= $signed(b);
      3'd6: take = a < b;
      3'd7: take = a >= b;
      default: take = 1'b0;
    endcase
  end

  // Memory access is done byte by byte so misaligned accesses wrap cleanly.
  assign nbytes = (f3[1:0] == 2'd0) ? 3'd1 : (f3[1:0] == 2'd1) ? 3'd2 : 3'd4;
  assign word_addr = DADDR_W'((addr + {30'd0, bidx}) >> 2);

  logic [1:0] lane;
  logic mem_phase;
  assign lane = addr[1:0] + bidx;
  logic [7:0] st_byte;
  assign st_byte = b[8*bidx +: 8];

  logic [31:0] merged;
  always_comb begin
    merged = ram_rdata;
    merged[8*lane +: 8] = st_byte;
  end

  // Store byte write happens in phase 1 using the freshly read word.
  logic st_we;
  assign st_we = (state == S_MEM) && mem_phase && (cur.cls == CLS_STORE);

  always_comb begin
    ram_we = st_we;
    ram_addr = word_addr;
    ram_wdata = merged;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
      ram_addr = clr_cnt;
      ram_wdata = '0;
    end
  end

  // Write-back waits only while the previous result is still unaccepted.
  assign wb_go = (state == S_WB) && (!res_valid || res_ready);

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    unique case (state)
      S_CLEAR: if (clr_cnt == DADDR_W'(DATA_WORDS - 1)) state_next = S_IDLE;
      S_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: state_next = (!halt_flag && (cur.cls == CLS_LOAD || cur.cls == CLS_STORE))
                           ? S_MEM : S_WB;
      S_MEM: if (mem_phase && bidx == 2'(nbytes - 3'd1)) state_next = S_WB;
      S_WB: if (wb_go) state_next = S_IDLE;
      S_HOLD: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    npc = pc + 32'd4;
    wr = 1'b0;
    val = 32'd0;
    unique case (cur.cls)
      CLS_ALU: begin val = alu_out; wr = 1'b1; end
      CLS_LOAD: begin
        val = ld_val;
        if (f3 == 3'd0) val = {{24{ld_val[7]}}, ld_val[7:0]};
        else if (f3 == 3'd1) val = {{16{ld_val[15]}}, ld_val[15:0]};
        wr = 1'b1;
      end
      CLS_BRANCH: if (take) npc = pc + cur.imm;
      CLS_JAL: begin val = pc + 32'd4; wr = 1'b1; npc = pc + cur.imm; end
      CLS_JALR: begin val = pc + 32'd4; wr = 1'b1; npc = (a + cur.imm) & ~32'd1; end
      CLS_LUI: begin val = cur.imm; wr = 1'b1; end
      CLS_AUIPC: begin val = pc + cur.imm; wr = 1'b1; end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE) || q_valid;

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
    if (state == S_EXEC) begin
      a <= (cur.word[19:15] == 5'd0) ? 32'd0 : regs[cur.word[19:15]];
      b <= (cur.word[24:20] == 5'd0) ? 32'd0 : regs[cur.word[24:20]];
    end
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      started <= 1'b0;
      halt_flag <= 1'b0;
      res_valid <= 1'b0;
      pc <= '0;
      bidx <= '0;
      mem_phase <= 1'b0;
      for (int i = 0; i < 32; i++) regs[i] <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (wb_go) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      if (q_pop && !started) begin
        started <= 1'b1;
        pc <= start_pc;
        regs[2] <= start_stack;
      end
      if (state == S_EXEC) begin
        addr <= ((cur.word[19:15] == 5'd0) ? 32'd0 : regs[cur.word[19:15]]) + cur.imm;
        bidx <= '0;
        mem_phase <= 1'b0;
        ld_val <= '0;
      end
      if (state == S_MEM) begin
        // Phase 0 issues the word read; phase 1 uses the data.
        if (!mem_phase) begin
          mem_phase <= 1'b1;
        end else begin
          mem_phase <= 1'b0;
          if (cur.cls == CLS_LOAD) ld_val[8*bidx +: 8] <= ram_rdata[8*lane +: 8];
          bidx <= bidx + 1'b1;
        end
      end
      if (wb_go) begin
        if (halt_flag || cur.cls == CLS_HALT) begin
          halt_flag <= 1'b1;
          res <= '{next_pc: pc, wrote_reg: 1'b0, dest_reg: 5'd0, dest_value: 32'd0,
                   mem_kind: KIND_NONE, mem_address: 32'd0, halted: 1'b1};
        end else begin
          pc <= npc;
          if (wr && rd != 5'd0) regs[rd] <= val;
          res.next_pc <= npc;
          res.wrote_reg <= wr && rd != 5'd0;
          res.dest_reg <= (wr && rd != 5'd0) ? rd : 5'd0;
          res.dest_value <= (wr && rd != 5'd0) ? val : 32'd0;
          res.mem_kind <= (cur.cls == CLS_LOAD) ? KIND_LOAD :
                          (cur.cls == CLS_STORE) ? KIND_STORE : KIND_NONE;
          res.mem_address <= (cur.cls == CLS_LOAD || cur.cls == CLS_STORE) ? addr : 32'd0;
          res.halted <= 1'b0;
        end
      end
    end
  end
endmodule

[rtl/rv32i_instruction_executor.sv]
// Top level of the RV32I instruction executor.
// Flow: an accepted item is queued, popped by the back end in S_IDLE, has its operands
// read in S_EXEC, passes through S_MEM for loads and stores (a read and a use phase per
// data byte, on the byte-serial single RAM port) and is written back in S_WB. The back end
// takes no new item until the last is written back; an unaccepted result stalls only the
// next write-back. Reset: synchronous; after reset a clearing pass zeroes all DATA_WORDS
// words of data memory, during which items queue but are not executed.
module rv32i_instruction_executor import rv32_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        instr_valid,
  output logic        instr_ready,
  input  logic [31:0] instr_word,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] next_pc,
  output logic        wrote_reg,
  output logic [4:0]  dest_reg,
  output logic [31:0] dest_value,
  output logic [1:0]  mem_kind,
  output logic [31:0] mem_address,
  output logic        halted
);
  logic [31:0] start_pc, start_stack;
  logic q_valid, q_pop, busy;
  dec_t q_head;
  res_t res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_START_STACK) ? start_stack : start_pc;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pc <= '0;
      start_stack <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_START_PC) start_pc <= pwdata;
      else start_stack <= pwdata;
    end
  end

  rv32_front u_front (
    .clk(clk), .rst(rst), .valid(instr_valid), .ready(instr_ready),
    .instr_word(instr_word), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
  );

  rv32_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
    .start_pc(start_pc), .start_stack(start_stack), .busy(busy),
    .res_valid(result_valid), .res_ready(result_ready), .res(res)
  );

  assign next_pc = res.next_pc;
  assign wrote_reg = res.wrote_reg;
  assign dest_reg = res.dest_reg;
  assign dest_value = res.dest_value;
  assign mem_kind = res.mem_kind;
  assign mem_address = res.mem_address;
  assign halted = res.halted;

  a_dest_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !wrote_reg |-> dest_reg == 5'd0 && dest_value == 32'd0)
    else $error("dest fields set without a register write");
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && halted |-> !wrote_reg && mem_kind == KIND_NONE)
    else $error("halted result reports activity");
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    instr_valid && instr_ready |=> busy)
    else $error("accepted item not tracked");
endmodule
